/* hdl/ppop_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppop_pkg: shared types and constants of the pixel point-operation engine
// Channel type, configuration bundle, mode and format codes, register indexes.
// ----------------------------------------------------------------------------
package ppop_pkg;

  localparam int NumLanes = 4;
  localparam int ChanW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumLanes-1:0][ChanW-1:0] pixel_t;

  // operation modes
  localparam logic [1:0] MODE_CONVERT  = 2'd0;
  localparam logic [1:0] MODE_BRIGHT   = 2'd1;
  localparam logic [1:0] MODE_CONTRAST = 2'd2;
  localparam logic [1:0] MODE_INVERT   = 2'd3;

  // pixel formats
  localparam logic [1:0] FMT_RGB  = 2'd0;
  localparam logic [1:0] FMT_RGBA = 2'd1;
  localparam logic [1:0] FMT_GRAY = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_FMT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TGT_FMT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BRIGHT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CONTRAST = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         src_fmt;
    logic [1:0]         tgt_fmt;
    logic signed [8:0]  bright;
    logic signed [10:0] contrast;
  } cfg_t;

  // unknown format code behaves as RGB
  function automatic logic [1:0] norm_fmt(input logic [1:0] f);
    return (f == FMT_RGBA || f == FMT_GRAY) ? f : FMT_RGB;
  endfunction

endpackage
`default_nettype wire

/* hdl/pixel_point_op_engine_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_point_op_engine_top: per-pixel format conversion and point operations
// Four channel lanes plus a luma unit feed a merge stage and an output register.
// ----------------------------------------------------------------------------
// Path: an accepted input passes the two lane stages and the output register to out_tdata.
// Throughput: one pixel per cycle while out_tready is not held low; the lanes are a
//   two-stage pipeline (the contrast path needs a product stage and a reciprocal-divide stage).
// Reset: rst_n synchronous, active low; clears all stage valids and loads
//   the registers with mode convert, RGB to RGB, offset 0, contrast 100.
// ----------------------------------------------------------------------------
module pixel_point_op_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input pixel stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // channel_0, channel_1, channel_2, channel_3
  input  wire logic        in_tlast,   // last_pixel
  // result pixel stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_channel_0 .. out_channel_3
  output logic             out_tlast,  // last_out
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import ppop_pkg::*;

  cfg_t   cfg_r;
  pixel_t in_pix;
  pixel_t lane_pix;
  pixel_t lane_res;
  chan_t  luma;
  pixel_t merged;

  logic   s1_v_r, s2_v_r, out_v_r;
  logic   last1_r, last2_r, last_out_r;
  pixel_t out_pix_r;
  logic   s1_adv, s2_adv, out_adv;

  logic signed [10:0] contrast_wr;

  // ---------------------------------------------------------------- config
  // Writes are always taken; clamp offsets to their legal range on the way in.
  assign cfg_ready   = 1'b1;
  assign contrast_wr = $signed(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= MODE_CONVERT;
      cfg_r.src_fmt  <= FMT_RGB;
      cfg_r.tgt_fmt  <= FMT_RGB;
      cfg_r.bright   <= '0;
      cfg_r.contrast <= 11'sd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:    cfg_r.mode    <= cfg_data[1:0];
        REG_SRC_FMT: cfg_r.src_fmt <= cfg_data[1:0];
        REG_TGT_FMT: cfg_r.tgt_fmt <= cfg_data[1:0];
        REG_BRIGHT: begin
          // most negative code saturates to -255
          if (cfg_data[8:0] == 9'h100) begin
            cfg_r.bright <= -9'sd255;
          end else begin
            cfg_r.bright <= $signed(cfg_data[8:0]);
          end
        end
        REG_CONTRAST: begin
          if (contrast_wr < -11'sd1000) begin
            cfg_r.contrast <= -11'sd1000;
          end else if (contrast_wr > 11'sd1000) begin
            cfg_r.contrast <= 11'sd1000;
          end else begin
            cfg_r.contrast <= contrast_wr;
          end
        end
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- pipeline
  // Each stage advances when it is empty or its successor advances, so the
  // input can still fill empty stages while a finished result waits in the output register.
  assign out_adv   = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r || out_adv;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // carry the frame-end mark alongside the lanes
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      last1_r <= in_tlast;
    end
    if (s2_adv) begin
      last2_r <= last1_r;
    end
    if (out_adv) begin
      last_out_r <= last2_r;
      out_pix_r  <= merged;
    end
  end

  // ----------------------------------------------------------------- lanes
  assign in_pix = in_tdata;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    ppop_lane u_lane (
      .clk     (clk),
      .en1     (s1_adv),
      .en2     (s2_adv),
      .pix_in  (in_pix[g]),
      .cfg     (cfg_r),
      .pix_out (lane_pix[g]),
      .res_out (lane_res[g])
    );
  end

  ppop_luma u_luma (
    .clk   (clk),
    .en1   (s1_adv),
    .en2   (s2_adv),
    .red   (in_pix[0]),
    .green (in_pix[1]),
    .blue  (in_pix[2]),
    .luma  (luma)
  );

  // ----------------------------------------------------------------- merge
  ppop_merge u_merge (
    .cfg    (cfg_r),
    .pix    (lane_pix),
    .res    (lane_res),
    .luma   (luma),
    .merged (merged)
  );

  // ---------------------------------------------------------------- output
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = last_out_r;

endmodule
`default_nettype wire

/* hdl/ppop_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppop_lane: per-channel point operation
// Two stages: centred product, then brightness / contrast / inversion.
// ----------------------------------------------------------------------------
module ppop_lane (
  input  wire logic           clk,
  input  wire logic           en1,
  input  wire logic           en2,
  input  wire ppop_pkg::chan_t pix_in,
  input  wire ppop_pkg::cfg_t  cfg,
  output ppop_pkg::chan_t      pix_out,
  output ppop_pkg::chan_t      res_out
);
  import ppop_pkg::*;

  logic signed [8:0]  centred;
  logic signed [19:0] prod;
  chan_t              p1_r;
  logic signed [19:0] prod1_r;

  logic signed [19:0] v;
  logic [27:0]        q_full;
  chan_t              contrast_res;
  logic signed [9:0]  bsum;
  chan_t              bright_res;
  chan_t              res_nxt;
  chan_t              res2_r;
  chan_t              pix2_r;

  assign centred = $signed({1'b0, pix_in}) - 9'sd128;
  assign prod    = 20'(centred) * 20'(cfg.contrast);

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_r    <= pix_in;
      prod1_r <= prod;
    end
  end

  // divide by 100 through reciprocal 5243 / 2^19, exact for 0..25599
  assign v      = prod1_r + 20'sd12800;
  assign q_full = 28'(v[14:0]) * 28'd5243;

  always_comb begin
    if (v[19]) begin
      contrast_res = '0;
    end else if (v >= 20'sd25600) begin
      contrast_res = 8'd255;
    end else begin
      contrast_res = q_full[26:19];
    end
  end

  assign bsum = $signed({2'b00, p1_r}) + $signed({cfg.bright[8], cfg.bright});

  always_comb begin
    if (bsum[9]) begin
      bright_res = '0;
    end else if (bsum > 10'sd255) begin
      bright_res = 8'd255;
    end else begin
      bright_res = bsum[7:0];
    end
  end

  always_comb begin
    case (cfg.mode)
      MODE_BRIGHT:   res_nxt = bright_res;
      MODE_CONTRAST: res_nxt = contrast_res;
      default:       res_nxt = 8'd255 - p1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      res2_r <= res_nxt;
      pix2_r <= p1_r;
    end
  end

  assign pix_out = pix2_r;
  assign res_out = res2_r;

endmodule
`default_nettype wire

/* hdl/ppop_luma.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppop_luma: BT.601 luma in 16-bit fixed point
// Weighted sum registered, then the top byte registered.
// ----------------------------------------------------------------------------
module ppop_luma (
  input  wire logic            clk,
  input  wire logic            en1,
  input  wire logic            en2,
  input  wire ppop_pkg::chan_t red,
  input  wire ppop_pkg::chan_t green,
  input  wire ppop_pkg::chan_t blue,
  output ppop_pkg::chan_t      luma
);
  import ppop_pkg::*;

  logic [23:0] sum;
  logic [23:0] sum1_r;
  chan_t       y2_r;

  assign sum = 24'(red) * 24'd19595 + 24'(green) * 24'd38470 + 24'(blue) * 24'd7471;

  always_ff @(posedge clk) begin
    if (en1) begin
      sum1_r <= sum;
    end
    if (en2) begin
      y2_r <= sum1_r[23:16];
    end
  end

  assign luma = y2_r;

endmodule
`default_nettype wire

/* hdl/ppop_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppop_merge: combine lane results into the result pixel
// Selects by mode and format; unused lanes give zero.
// ----------------------------------------------------------------------------
module ppop_merge (
  input  wire ppop_pkg::cfg_t   cfg,
  input  wire ppop_pkg::pixel_t pix,
  input  wire ppop_pkg::pixel_t res,
  input  wire ppop_pkg::chan_t  luma,
  output ppop_pkg::pixel_t      merged
);
  import ppop_pkg::*;

  logic [1:0]          sf;
  logic [1:0]          tf;
  logic [NumLanes-1:0] used;

  assign sf = norm_fmt(cfg.src_fmt);
  assign tf = norm_fmt(cfg.tgt_fmt);

  always_comb begin
    case (sf)
      FMT_RGBA: used = 4'b1111;
      FMT_GRAY: used = 4'b0001;
      default:  used = 4'b0111;
    endcase
  end

  always_comb begin
    merged = '0;
    if (cfg.mode == MODE_CONVERT) begin
      if (sf == tf) begin
        for (int i = 0; i < NumLanes; i++) begin
          merged[i] = used[i] ? pix[i] : '0;
        end
      end else if (tf == FMT_GRAY) begin
        merged[0] = luma;
      end else begin
        // replicate gray, or pass RGB; add opaque alpha for RGBA
        merged[0] = pix[0];
        merged[1] = (sf == FMT_GRAY) ? pix[0] : pix[1];
        merged[2] = (sf == FMT_GRAY) ? pix[0] : pix[2];
        merged[3] = (tf == FMT_RGBA) ? 8'd255 : 8'd0;
      end
    end else begin
      for (int i = 0; i < NumLanes; i++) begin
        merged[i] = used[i] ? res[i] : '0;
      end
    end
  end

endmodule
`default_nettype wire
